FILE: design/fmti_pkg.sv
// ----------------------------------------------------------------------------
// fmti_pkg
// Shared types, constants and helpers for the formatted integer to ASCII
// block: controller states, command and status bundles, character codes.
// ----------------------------------------------------------------------------
package fmti_pkg;

  // Quotient bits resolved per divide cycle
  localparam int DIV_STEP_BITS = 8;

  localparam int BASE_MIN  = 2;
  localparam int BASE_MAX  = 36;
  localparam int PREC_CAP  = 60;
  localparam int MAX_RUN   = 64;
  localparam int HEX_BASE  = 16;
  localparam int OCT_BASE  = 8;
  localparam int X_DIGIT   = 33;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIVIDE = 5'b00010,
    ST_SIZE   = 5'b00100,
    ST_PLAN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    SIGN_NONE  = 2'd0,
    SIGN_MINUS = 2'd1,
    SIGN_PLUS  = 2'd2,
    SIGN_SPACE = 2'd3
  } sign_t;

  typedef enum logic [2:0] {
    SEG_SPACE = 3'd0,
    SEG_SIGN  = 3'd1,
    SEG_ZERO  = 3'd2,
    SEG_XCHAR = 3'd3,
    SEG_DIGIT = 3'd4,
    SEG_ERR   = 3'd5
  } seg_t;

  typedef struct packed {
    logic load;
    logic err;
    logic div_step;
    logic digit_end;
    logic size;
    logic plan;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic base_ok;
    logic div_done;
    logic emit_last;
  } sts_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = CH_ZERO + 8'(d);
    end else if (lower) begin
      c = CH_LOWER_A + 8'(d) - 8'd10;
    end else begin
      c = CH_UPPER_A + 8'(d) - 8'd10;
    end
    return c;
  endfunction

endpackage

FILE: design/fmti_ctrl.sv
// ----------------------------------------------------------------------------
// fmti_ctrl
// Sequencer for the conversion: accepts a request, runs the digit divide
// loop, sizes the padding, plans the character layout and steps emission.
// ----------------------------------------------------------------------------
module fmti_ctrl #(
  parameter int VALUE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  fmti_pkg::sts_t  sts,
  output fmti_pkg::cmd_t  cmd
);

  localparam int DIV_CYCLES =
    (VALUE_BITS + fmti_pkg::DIV_STEP_BITS - 1) / fmti_pkg::DIV_STEP_BITS;
  localparam int SW = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  fmti_pkg::state_t state, state_next;
  logic [SW-1:0]    step, step_next;
  logic             digit_end;

  assign busy      = (state != fmti_pkg::ST_IDLE);
  assign digit_end = (state == fmti_pkg::ST_DIVIDE) && (step == SW'(DIV_CYCLES - 1));

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    cmd.digit_end = digit_end;
    case (state)
      fmti_pkg::ST_IDLE: begin
        step_next = '0;
        if (start) begin
          if (sts.base_ok) begin
            cmd.load   = 1'b1;
            state_next = fmti_pkg::ST_DIVIDE;
          end else begin
            cmd.err = 1'b1;
          end
        end
      end
      fmti_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (digit_end) begin
          step_next = '0;
          if (sts.div_done) begin
            state_next = fmti_pkg::ST_SIZE;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      fmti_pkg::ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = fmti_pkg::ST_PLAN;
      end
      fmti_pkg::ST_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = fmti_pkg::ST_EMIT;
      end
      fmti_pkg::ST_EMIT: begin
        cmd.emit_step = 1'b1;
        if (sts.emit_last) begin
          state_next = fmti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fmti_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmti_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  a_load_enters_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == fmti_pkg::ST_DIVIDE))
    else $error("load did not enter divide");

  a_divide_starts_at_step0: assert property (@(posedge clk) disable iff (rst)
    $rose(state == fmti_pkg::ST_DIVIDE) |-> (step == '0))
    else $error("divide entered with stale step count");

  a_emit_end_frees: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_step && sts.emit_last) |=> !busy)
    else $error("still busy after final character");

  a_err_while_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.err |=> (state == fmti_pkg::ST_IDLE))
    else $error("error request left idle");

endmodule

FILE: design/fmti_dpath.sv
// ----------------------------------------------------------------------------
// fmti_dpath
// Datapath: sign and magnitude capture, multi-bit restoring divider, digit
// memory, padding arithmetic, layout boundaries and the character pipeline.
// ----------------------------------------------------------------------------
module fmti_dpath #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_DEPTH = 32,
  parameter int MAX_WIDTH   = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fmti_pkg::cmd_t        cmd,
  output fmti_pkg::sts_t        sts,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [5:0]            base,
  input  logic [5:0]            field_width,
  input  logic [5:0]            min_digits,
  input  logic                  zero_pad,
  input  logic                  signed_mode,
  input  logic                  force_plus,
  input  logic                  space_sign,
  input  logic                  left_justify,
  input  logic                  alt_prefix,
  input  logic                  lower_case,
  output logic                  strobe,
  output logic [7:0]            out_char,
  output logic                  last,
  output logic                  bad_base
);

  localparam int STEP_BITS  = fmti_pkg::DIV_STEP_BITS;
  localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int QW         = DIV_CYCLES * STEP_BITS;
  localparam int AW         = $clog2(DIGIT_DEPTH);
  localparam int CW         = $clog2(DIGIT_DEPTH + 1);

  // Per-request settings
  logic [5:0]       base_r;
  logic [5:0]       width_r;
  logic [5:0]       prec_r;
  fmti_pkg::sign_t  sign_r;
  logic [1:0]       pfx_len;
  logic             zpad_r;
  logic             left_r;
  logic             lower_r;

  // Divider
  logic [QW-1:0]    q, q_w;
  logic [5:0]       r, r_w;
  logic [CW-1:0]    cnt;
  logic [5:0]       digit_mem [DIGIT_DEPTH];

  // Layout
  logic [6:0]       pad_r, zfill_r;
  logic [7:0]       b1, b2, b3, b4, b5;
  logic [5:0]       last_pos;
  logic [5:0]       pos;

  // Character pipeline
  logic             valid_q;
  fmti_pkg::seg_t   seg_q;
  logic             last_q;
  logic [5:0]       rd_data;

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  base_ok;
  logic [6:0]            cnt7, prec_eff;
  logic [7:0]            fixed_len, width8;
  logic                  sign_len;
  logic [7:0]            lead, pb1, pb2, pb3, pb4, pb5, total, run_len;
  logic [7:0]            pos8, idx8;
  fmti_pkg::seg_t        seg;
  logic [7:0]            seg_char;

  assign base_ok = (base >= 6'(fmti_pkg::BASE_MIN)) && (base <= 6'(fmti_pkg::BASE_MAX));
  assign neg     = signed_mode && value[VALUE_BITS-1];
  assign mag     = neg ? (VALUE_BITS'(0) - value) : value;

  // STEP_BITS restoring division steps per cycle on a 6-bit remainder
  always_comb begin
    logic [6:0] r_t;
    q_w = q;
    r_w = r;
    for (int i = 0; i < STEP_BITS; i++) begin
      r_t = {r_w, q_w[QW-1]};
      if (r_t >= {1'b0, base_r}) begin
        r_t = r_t - {1'b0, base_r};
        q_w = {q_w[QW-2:0], 1'b1};
      end else begin
        q_w = {q_w[QW-2:0], 1'b0};
      end
      r_w = r_t[5:0];
    end
  end

  // Padding size once the digit count is known
  assign sign_len  = (sign_r != fmti_pkg::SIGN_NONE);
  assign cnt7      = 7'(cnt);
  assign prec_eff  = (7'(prec_r) > cnt7) ? 7'(prec_r) : cnt7;
  assign fixed_len = 8'(prec_eff) + 8'(sign_len) + 8'(pfx_len);
  assign width8    = 8'(width_r);

  // Segment boundaries of the character run
  assign lead    = (!zpad_r && !left_r) ? 8'(pad_r) : 8'd0;
  assign pb1     = lead;
  assign pb2     = pb1 + 8'(sign_len);
  assign pb3     = pb2 + 8'(pfx_len);
  assign pb4     = pb3 + 8'(zfill_r) + (zpad_r ? 8'(pad_r) : 8'd0);
  assign pb5     = pb4 + 8'(cnt7);
  assign total   = pb5 + (left_r ? 8'(pad_r) : 8'd0);
  assign run_len = (total > 8'(fmti_pkg::MAX_RUN)) ? 8'(fmti_pkg::MAX_RUN) : total;

  // Classify the current position
  assign pos8 = 8'(pos);
  assign idx8 = b5 - 8'd1 - pos8;
  always_comb begin
    if (pos8 < b1) begin
      seg = fmti_pkg::SEG_SPACE;
    end else if (pos8 < b2) begin
      seg = fmti_pkg::SEG_SIGN;
    end else if (pos8 < b3) begin
      seg = (pos8 == b2) ? fmti_pkg::SEG_ZERO : fmti_pkg::SEG_XCHAR;
    end else if (pos8 < b4) begin
      seg = fmti_pkg::SEG_ZERO;
    end else if (pos8 < b5) begin
      seg = fmti_pkg::SEG_DIGIT;
    end else begin
      seg = fmti_pkg::SEG_SPACE;
    end
  end

  always_comb begin
    case (seg_q)
      fmti_pkg::SEG_SPACE: seg_char = fmti_pkg::CH_SPACE;
      fmti_pkg::SEG_SIGN: begin
        case (sign_r)
          fmti_pkg::SIGN_MINUS: seg_char = fmti_pkg::CH_MINUS;
          fmti_pkg::SIGN_PLUS:  seg_char = fmti_pkg::CH_PLUS;
          default:              seg_char = fmti_pkg::CH_SPACE;
        endcase
      end
      fmti_pkg::SEG_ZERO:  seg_char = fmti_pkg::CH_ZERO;
      fmti_pkg::SEG_XCHAR: seg_char = fmti_pkg::digit_char(6'(fmti_pkg::X_DIGIT), lower_r);
      fmti_pkg::SEG_DIGIT: seg_char = fmti_pkg::digit_char(rd_data, lower_r);
      default:             seg_char = fmti_pkg::CH_NUL;
    endcase
  end

  assign sts.base_ok   = base_ok;
  assign sts.div_done  = (q_w == '0) || (cnt == CW'(DIGIT_DEPTH - 1));
  assign sts.emit_last = (pos == last_pos);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q       <= QW'(mag);
      r       <= '0;
      cnt     <= '0;
      base_r  <= base;
      width_r <= (field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width;
      prec_r  <= (min_digits > 6'(fmti_pkg::PREC_CAP)) ? 6'(fmti_pkg::PREC_CAP)
                                                      : min_digits;
      zpad_r  <= zero_pad && !left_justify;
      left_r  <= left_justify;
      lower_r <= lower_case;
      if (neg) begin
        sign_r <= fmti_pkg::SIGN_MINUS;
      end else if (force_plus) begin
        sign_r <= fmti_pkg::SIGN_PLUS;
      end else if (space_sign) begin
        sign_r <= fmti_pkg::SIGN_SPACE;
      end else begin
        sign_r <= fmti_pkg::SIGN_NONE;
      end
      if (alt_prefix && base == 6'(fmti_pkg::HEX_BASE)) begin
        pfx_len <= 2'd2;
      end else if (alt_prefix && base == 6'(fmti_pkg::OCT_BASE)) begin
        pfx_len <= 2'd1;
      end else begin
        pfx_len <= 2'd0;
      end
    end

    if (cmd.div_step) begin
      q <= q_w;
      if (cmd.digit_end) begin
        digit_mem[cnt[AW-1:0]] <= r_w;
        cnt <= cnt + 1'b1;
        r   <= '0;
      end else begin
        r <= r_w;
      end
    end

    if (cmd.size) begin
      pad_r   <= (width8 > fixed_len) ? 7'(width8 - fixed_len) : 7'd0;
      zfill_r <= prec_eff - cnt7;
    end

    if (cmd.plan) begin
      b1       <= pb1;
      b2       <= pb2;
      b3       <= pb3;
      b4       <= pb4;
      b5       <= pb5;
      last_pos <= 6'(run_len - 8'd1);
      pos      <= '0;
    end

    if (cmd.emit_step) begin
      pos <= pos + 1'b1;
      if (seg == fmti_pkg::SEG_DIGIT) begin
        rd_data <= digit_mem[idx8[AW-1:0]];
      end
    end

    // Stage one: position classified, digit fetched
    if (cmd.err) begin
      seg_q  <= fmti_pkg::SEG_ERR;
      last_q <= 1'b1;
    end else if (cmd.emit_step) begin
      seg_q  <= seg;
      last_q <= (pos == last_pos);
    end

    // Stage two: result registers
    out_char <= seg_char;
    last     <= last_q;
    bad_base <= (seg_q == fmti_pkg::SEG_ERR);

    if (rst) begin
      valid_q <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      valid_q <= cmd.err || cmd.emit_step;
      strobe  <= valid_q;
    end
  end

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("character run broken before its last character");

endmodule

FILE: design/formatted_integer_to_ascii.sv
// A request with a valid base keeps busy high while the shared divider
// resolves 8 quotient bits per divide cycle for each digit, and while its
// characters, up to 64 of them, are emitted. Each character passes the
// stage one register (seg_q) and then the stage two result register after
// its emit step. A bad base returns one error result through the same
// registers and leaves busy low. Reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
// formatted_integer_to_ascii
// printf-style integer conversion: radix digits, sign, prefix and padding,
// streamed out one ASCII character per strobe.
// ----------------------------------------------------------------------------
module formatted_integer_to_ascii #(
  parameter int VALUE_BITS  = 32,
  parameter int DIGIT_DEPTH = 32,
  parameter int MAX_WIDTH   = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [5:0]            base,
  input  logic [5:0]            field_width,
  input  logic [5:0]            min_digits,
  input  logic                  zero_pad,
  input  logic                  signed_mode,
  input  logic                  force_plus,
  input  logic                  space_sign,
  input  logic                  left_justify,
  input  logic                  alt_prefix,
  input  logic                  lower_case,
  output logic                  strobe,
  output logic [7:0]            out_char,
  output logic                  last,
  output logic                  bad_base
);

  fmti_pkg::cmd_t cmd;
  fmti_pkg::sts_t sts;

  fmti_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  fmti_dpath #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_DEPTH (DIGIT_DEPTH),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .value        (value),
    .base         (base),
    .field_width  (field_width),
    .min_digits   (min_digits),
    .zero_pad     (zero_pad),
    .signed_mode  (signed_mode),
    .force_plus   (force_plus),
    .space_sign   (space_sign),
    .left_justify (left_justify),
    .alt_prefix   (alt_prefix),
    .lower_case   (lower_case),
    .strobe       (strobe),
    .out_char     (out_char),
    .last         (last),
    .bad_base     (bad_base)
  );

endmodule
